>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies the consequent in the same cycle.
`define MSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define MSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/msu_pkg.sv
`default_nettype none
package msu_pkg;

	localparam int ATOM_COUNT    = 1024;
	localparam int ATOM_W        = 10;
	localparam int MAX_NEIGHBORS = 16;
	localparam int SLOT_W        = 4;
	localparam int MAT_W         = 4;
	localparam int CPL_DEPTH     = 144;
	localparam int CPL_AW        = 8;
	localparam int NB_DEPTH      = ATOM_COUNT * MAX_NEIGHBORS;
	localparam int NB_AW         = ATOM_W + SLOT_W;
	localparam int NCNT_W        = 5;
	localparam int EXP_SIZE      = 256;
	localparam int DRAIN_CYCLES  = 4;
	localparam logic [63:0] EXP_RATIO = 64'd4034748382;

	localparam logic [2:0] MODE_CPL   = 3'd0;
	localparam logic [2:0] MODE_ATOM  = 3'd1;
	localparam logic [2:0] MODE_NB    = 3'd2;
	localparam logic [2:0] MODE_TRIAL = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;
	localparam logic [2:0] MODE_CLEAR = 3'd5;

	localparam logic [3:0] SLOT_CPL_LAST  = 4'd8;
	localparam logic [3:0] SLOT_SPIN_LAST = 4'd2;
	localparam logic [3:0] SLOT_ANI_FIRST = 4'd3;
	localparam logic [3:0] SLOT_ANI_LAST  = 4'd5;
	localparam logic [3:0] SLOT_NCNT      = 4'd6;

	typedef logic [EXP_SIZE-1:0][15:0] exp_tab_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [9:0]  atom_index;
		logic [3:0]  slot_index;
		logic [9:0]  link_index;
		logic [3:0]  matrix_index;
		logic [15:0] value;
		logic [15:0] prop_x;
		logic [15:0] prop_y;
		logic [15:0] prop_z;
		logic [15:0] uniform;
	} msu_item_t;

	typedef struct packed {
		logic [15:0] spin_x;
		logic [15:0] spin_y;
		logic [15:0] spin_z;
		logic        accepted;
		logic [31:0] energy_delta;
		logic [31:0] flip_count;
	} msu_result_t;

	typedef struct packed {
		logic              take;
		logic              exec;
		logic              clr_wr;
		logic [ATOM_W-1:0] clr_addr;
		logic              self_rd;
		logic              trial_lat;
		logic              nb_rd;
		logic [SLOT_W-1:0] nb_slot;
		logic              link_rd;
		logic              link_lat;
		logic              inject;
		logic              aniso;
		logic [3:0]        k;
		logic              q_calc;
		logic              div_init;
		logic              div_step;
		logic [2:0]        div_bit;
		logic              decide;
		logic              commit;
		logic              out_load;
	} msu_cmd_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [NCNT_W-1:0] n;
		logic              need_div;
		logic              too_big;
		logic              out_free;
	} msu_stat_t;

	// exp(-x/16) in Q0.16, built from a repeated Q0.32 product with rounding.
	function automatic exp_tab_t exp_build();
		logic [63:0] acc;
		logic [63:0] e;
		exp_tab_t    t;
		acc = 64'd1 << 32;
		for (int i = 0; i < EXP_SIZE; i++) begin
			e = (acc + 64'h8000) >> 16;
			t[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
			acc = (acc * EXP_RATIO + 64'h8000_0000) >> 32;
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TABLE = exp_build();

	// Column and row of a row-major 3x3 element.
	function automatic logic [1:0] el_col(input logic [3:0] k);
		case (k)
			4'd1, 4'd4, 4'd7: el_col = 2'd1;
			4'd2, 4'd5, 4'd8: el_col = 2'd2;
			default:          el_col = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] el_row(input logic [3:0] k);
		case (k)
			4'd3, 4'd4, 4'd5: el_row = 2'd1;
			4'd6, 4'd7, 4'd8: el_row = 2'd2;
			default:          el_row = 2'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/msu_in_if.sv
`default_nettype none
interface msu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [9:0]  atom_index;
	logic [3:0]  slot_index;
	logic [9:0]  link_index;
	logic [3:0]  matrix_index;
	logic signed [15:0] value;
	logic signed [15:0] prop_x;
	logic signed [15:0] prop_y;
	logic signed [15:0] prop_z;
	logic [15:0] uniform;

	modport source (output valid, mode, atom_index, slot_index, link_index, matrix_index,
		value, prop_x, prop_y, prop_z, uniform, input ready);
	modport sink (input valid, mode, atom_index, slot_index, link_index, matrix_index,
		value, prop_x, prop_y, prop_z, uniform, output ready);
	modport monitor (input valid, ready, mode, atom_index, slot_index, link_index,
		matrix_index, value, prop_x, prop_y, prop_z, uniform);
endinterface
`default_nettype wire

>>> rtl/msu_out_if.sv
`default_nettype none
interface msu_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] spin_x;
	logic signed [15:0] spin_y;
	logic signed [15:0] spin_z;
	logic        accepted;
	logic signed [31:0] energy_delta;
	logic [31:0] flip_count;

	modport source (output valid, spin_x, spin_y, spin_z, accepted, energy_delta,
		flip_count, input ready);
	modport sink (input valid, spin_x, spin_y, spin_z, accepted, energy_delta,
		flip_count, output ready);
	modport monitor (input valid, ready, spin_x, spin_y, spin_z, accepted, energy_delta,
		flip_count);
endinterface
`default_nettype wire

>>> rtl/msu_datapath.sv
`default_nettype none
module msu_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  msu_pkg::msu_cmd_t    cmd,
	input  msu_pkg::msu_item_t   item_in,
	input  logic                 cfg_we,
	input  logic [23:0]          cfg_data,
	input  logic                 res_ready,
	output logic                 res_valid,
	output msu_pkg::msu_result_t res_out,
	output msu_pkg::msu_stat_t   stat
);
	import msu_pkg::*;

	msu_item_t it_q;
	logic [23:0] temp_q;

	logic [2:0][15:0] spin_mem [ATOM_COUNT];
	logic [2:0][15:0] ani_mem [ATOM_COUNT];
	logic [NCNT_W-1:0] ncnt_mem [ATOM_COUNT];
	logic [13:0] nb_mem [NB_DEPTH];
	logic [15:0] cpl_mem [CPL_DEPTH];

	logic [2:0][15:0] spin_rd_q, ani_rd_q;
	logic [NCNT_W-1:0] ncnt_rd_q;
	logic [13:0] nb_q;

	logic signed [2:0][16:0] diff_q, sum_q;
	logic [2:0][15:0] d_q, nspin_q;
	logic [NCNT_W-1:0] n_q;

	logic        v_s1, an_s1, v_s2, an_s2, v_s3, an_s3, v_s4;
	logic [3:0]  k_s1, k_s2, k_s3;
	logic [15:0] cpl_s1;
	logic signed [33:0] p1_s2;
	logic signed [34:0] row_s3;
	logic signed [50:0] p2_s4;
	logic signed [55:0] energy_q;

	logic [31:0] dq_q, rem_q, cnt_q;
	logic        neg_q, accept_q;
	logic [7:0]  idx_q;

	logic [2:0][15:0] prop;
	logic        is_atom, spin_we, ani_we;
	logic [2:0]  spin_len;
	logic [1:0]  wlane;
	logic [ATOM_W-1:0] spin_ra;
	logic [CPL_AW-1:0] cpl_wa, cpl_ra;
	logic [NCNT_W-1:0] ncnt_sat;
	logic [1:0]  c1, c3, r3;
	logic signed [16:0] m1a, m1b;
	logic signed [15:0] m2b;
	logic signed [55:0] rnd;
	logic [23:0] t_eff;
	logic [35:0] num, tlim;
	logic [31:0] sub;
	logic        need_div, too_big;

	assign prop = {it_q.prop_z, it_q.prop_y, it_q.prop_x};
	assign is_atom = cmd.exec && (it_q.mode == MODE_ATOM);
	assign spin_we = (is_atom && (it_q.slot_index <= SLOT_SPIN_LAST)) ||
		(cmd.commit && accept_q);
	assign ani_we = is_atom && (it_q.slot_index >= SLOT_ANI_FIRST) &&
		(it_q.slot_index <= SLOT_ANI_LAST);
	assign wlane = ani_we ? 2'(it_q.slot_index - SLOT_ANI_FIRST) : it_q.slot_index[1:0];
	assign spin_len = cmd.commit ? 3'b111 : (3'b001 << wlane);
	assign spin_ra = cmd.link_rd ? nb_q[13:4] : it_q.atom_index;
	assign cpl_wa = {1'b0, it_q.matrix_index, 3'b000} + {4'b0, it_q.matrix_index} +
		{4'b0, it_q.slot_index};
	assign cpl_ra = {1'b0, nb_q[3:0], 3'b000} + {4'b0, nb_q[3:0]} + {4'b0, cmd.k};

	always_comb begin
		if (it_q.value[15])
			ncnt_sat = '0;
		else if (it_q.value > 16'(MAX_NEIGHBORS))
			ncnt_sat = NCNT_W'(MAX_NEIGHBORS);
		else
			ncnt_sat = it_q.value[NCNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			it_q <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			temp_q <= 24'd65536;
		else if (cfg_we)
			temp_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (spin_we && spin_len[l])
				spin_mem[it_q.atom_index][l] <= cmd.commit ? prop[l] : it_q.value;
		end
		if (cmd.self_rd || cmd.link_rd)
			spin_rd_q <= spin_mem[spin_ra];
	end

	always_ff @(posedge clk) begin
		if (ani_we)
			ani_mem[it_q.atom_index][wlane] <= it_q.value;
		if (cmd.self_rd)
			ani_rd_q <= ani_mem[it_q.atom_index];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			ncnt_mem[cmd.clr_addr] <= '0;
		else if (is_atom && (it_q.slot_index == SLOT_NCNT))
			ncnt_mem[it_q.atom_index] <= ncnt_sat;
		if (cmd.self_rd)
			ncnt_rd_q <= ncnt_mem[it_q.atom_index];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (it_q.mode == MODE_NB))
			nb_mem[{it_q.atom_index, it_q.slot_index}] <= {it_q.link_index, it_q.matrix_index};
		if (cmd.nb_rd)
			nb_q <= nb_mem[{it_q.atom_index, cmd.nb_slot}];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (it_q.mode == MODE_CPL) && (it_q.slot_index <= SLOT_CPL_LAST))
			cpl_mem[cpl_wa] <= it_q.value;
		if (cmd.inject && !cmd.aniso)
			cpl_s1 <= cpl_mem[cpl_ra];
	end

	// Per-trial operands: spin change and spin sum per component, anisotropy, neighbour count, neighbour spin.
	always_ff @(posedge clk) begin
		if (cmd.trial_lat) begin
			for (int c = 0; c < 3; c++) begin
				diff_q[c] <= {spin_rd_q[c][15], spin_rd_q[c]} - {prop[c][15], prop[c]};
				sum_q[c]  <= {spin_rd_q[c][15], spin_rd_q[c]} + {prop[c][15], prop[c]};
			end
			d_q <= ani_rd_q;
			n_q <= ncnt_rd_q;
		end
		if (cmd.link_lat)
			nspin_q <= spin_rd_q;
	end

	// Product pipeline: element (or spin sum) times spin change, row sum, row times neighbour spin (or anisotropy).
	assign c1  = el_col(k_s1);
	assign c3  = el_col(k_s3);
	assign r3  = el_row(k_s3);
	assign m1a = an_s1 ? sum_q[c1] : {cpl_s1[15], cpl_s1};
	assign m1b = diff_q[c1];
	assign m2b = an_s3 ? d_q[c3] : nspin_q[r3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.inject;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && (an_s3 || (c3 == 2'd2));
		end
	end

	always_ff @(posedge clk) begin
		an_s1 <= cmd.aniso;
		k_s1  <= cmd.k;
		an_s2 <= an_s1;
		k_s2  <= k_s1;
		p1_s2 <= m1a * m1b;
		an_s3 <= an_s2;
		k_s3  <= k_s2;
		if (v_s2) begin
			if (an_s2 || (el_col(k_s2) == 2'd0))
				row_s3 <= {p1_s2[33], p1_s2};
			else
				row_s3 <= row_s3 + {p1_s2[33], p1_s2};
		end
		p2_s4 <= row_s3 * m2b;
	end

	always_ff @(posedge clk) begin
		if (cmd.trial_lat)
			energy_q <= '0;
		else if (v_s4)
			energy_q <= energy_q + {{5{p2_s4[50]}}, p2_s4};
	end

	// Rounding, acceptance test and long division by the temperature.
	assign rnd      = energy_q + 56'sd33554432;
	assign t_eff    = (temp_q == '0) ? 24'd1 : temp_q;
	assign num      = {dq_q, 4'b0000};
	assign tlim     = {4'b0000, t_eff, 8'b0000_0000};
	assign need_div = !neg_q && (dq_q != '0);
	assign too_big  = num >= tlim;
	assign sub      = {8'b0, t_eff} << cmd.div_bit;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= num[31:0];
			idx_q <= '0;
		end else if (cmd.div_step && (rem_q >= sub)) begin
			rem_q <= rem_q - sub;
			idx_q[cmd.div_bit] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q     <= '0;
			neg_q    <= 1'b0;
			accept_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cmd.take) begin
				dq_q     <= '0;
				accept_q <= 1'b0;
			end
			if (cmd.q_calc) begin
				dq_q  <= {{2{rnd[55]}}, rnd[55:26]};
				neg_q <= energy_q[55];
			end
			if (cmd.decide)
				accept_q <= !need_div || (!too_big && (it_q.uniform < EXP_TABLE[idx_q]));
			if (cmd.exec && (it_q.mode == MODE_CLEAR))
				cnt_q <= '0;
			else if (cmd.commit && accept_q)
				cnt_q <= cnt_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (cmd.out_load)
			res_valid <= 1'b1;
		else if (res_ready)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_out.spin_x       <= spin_rd_q[0];
			res_out.spin_y       <= spin_rd_q[1];
			res_out.spin_z       <= spin_rd_q[2];
			res_out.accepted     <= accept_q;
			res_out.energy_delta <= dq_q;
			res_out.flip_count   <= cnt_q;
		end
	end

	assign stat.mode     = it_q.mode;
	assign stat.n        = n_q;
	assign stat.need_div = need_div;
	assign stat.too_big  = too_big;
	assign stat.out_free = !res_valid || res_ready;

endmodule
`default_nettype wire

>>> rtl/msu_ctrl.sv
`default_nettype none
module msu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  msu_pkg::msu_stat_t stat,
	output msu_pkg::msu_cmd_t  cmd
);
	import msu_pkg::*;

	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_EXEC   = 5'd2;
	localparam logic [4:0] S_T_RD   = 5'd3;
	localparam logic [4:0] S_T_LAT  = 5'd4;
	localparam logic [4:0] S_AN     = 5'd5;
	localparam logic [4:0] S_DRN    = 5'd6;
	localparam logic [4:0] S_NB_RD  = 5'd7;
	localparam logic [4:0] S_NB_WT  = 5'd8;
	localparam logic [4:0] S_EL     = 5'd9;
	localparam logic [4:0] S_Q      = 5'd10;
	localparam logic [4:0] S_CHK    = 5'd11;
	localparam logic [4:0] S_DIV    = 5'd12;
	localparam logic [4:0] S_DEC    = 5'd13;
	localparam logic [4:0] S_COMMIT = 5'd14;
	localparam logic [4:0] S_RD     = 5'd15;
	localparam logic [4:0] S_OUT    = 5'd16;

	logic [4:0] state_q, state_d;
	logic [3:0] k_q, k_d;
	logic [NCNT_W-1:0] j_q, j_d;
	logic [1:0] dr_q, dr_d;
	logic [2:0] b_q, b_d;
	logic [ATOM_W-1:0] clr_q, clr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			k_q     <= '0;
			j_q     <= '0;
			dr_q    <= '0;
			b_q     <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			j_q     <= j_d;
			dr_q    <= dr_d;
			b_q     <= b_d;
			clr_q   <= clr_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		j_d          = j_q;
		dr_d         = dr_q;
		b_d          = b_q;
		clr_d        = clr_q;
		cmd          = '0;
		cmd.clr_addr = clr_q;
		cmd.nb_slot  = j_q[SLOT_W-1:0];
		cmd.k        = k_q;
		cmd.div_bit  = b_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == ATOM_W'(ATOM_COUNT - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = (stat.mode == MODE_TRIAL) ? S_T_RD : S_RD;
			end
			S_T_RD: begin
				cmd.self_rd = 1'b1;
				state_d = S_T_LAT;
			end
			S_T_LAT: begin
				cmd.trial_lat = 1'b1;
				k_d = '0;
				j_d = '0;
				state_d = S_AN;
			end
			S_AN: begin
				cmd.inject = 1'b1;
				cmd.aniso = 1'b1;
				k_d = k_q + 1'b1;
				if (k_q == 4'd2) begin
					k_d = '0;
					dr_d = '0;
					state_d = S_DRN;
				end
			end
			S_DRN: begin
				dr_d = dr_q + 1'b1;
				if (dr_q == 2'(DRAIN_CYCLES - 1))
					state_d = (j_q == stat.n) ? S_Q : S_NB_RD;
			end
			S_NB_RD: begin
				cmd.nb_rd = 1'b1;
				state_d = S_NB_WT;
			end
			S_NB_WT: begin
				cmd.link_rd = 1'b1;
				state_d = S_EL;
			end
			S_EL: begin
				cmd.inject = 1'b1;
				cmd.link_lat = (k_q == '0);
				k_d = k_q + 1'b1;
				if (k_q == SLOT_CPL_LAST) begin
					k_d = '0;
					j_d = j_q + 1'b1;
					dr_d = '0;
					state_d = S_DRN;
				end
			end
			S_Q: begin
				cmd.q_calc = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.need_div && !stat.too_big) begin
					cmd.div_init = 1'b1;
					b_d = 3'd7;
					state_d = S_DIV;
				end else begin
					state_d = S_DEC;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				b_d = b_q - 1'b1;
				if (b_q == '0)
					state_d = S_DEC;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.self_rd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/metropolis_spin_update_engine.sv
`default_nettype none
// Metropolis spin update engine. Words on the item channel load the coupling matrices,
// per-atom spin, anisotropy and neighbour count, and neighbour links; a trial word proposes
// a new spin for one atom and is accepted when the local energy does not rise, or otherwise
// when the uniform number lies below exp(-delta/T). Every word returns exactly one result
// word with the atom's spin after the word, the acceptance flag, the rounded Q16.16 energy
// change (zero for anything other than a trial) and the flip count. After reset the engine
// sweeps the neighbour count store to zero, one atom a cycle, over all 1024 atoms, and takes
// no word until that sweep is done; temperature writes are taken at any time. Words are
// handled one at a time. A load, read or clear word is executed, then the atom's spin is
// read and the result is loaded into the output register once that register is free. A
// trial streams, for each neighbour, a link fetch and nine coupling elements from the
// coupling memory through the shared multiply-accumulate pipeline, then drains that
// pipeline before the next neighbour's spin is used; the acceptance test divides by the
// temperature only when the energy rose and the quotient index fits the table.
// The division is bit-serial, one quotient bit a cycle over the eight bits of the table index.
// A finished result sits in an output register, so the next word is taken while it waits.
module metropolis_spin_update_engine (
	input  logic         clk,
	input  logic         arst_n,
	msu_in_if.sink       item,
	msu_out_if.source    result,
	input  logic         cfg_we,
	input  logic [23:0]  cfg_data
);
	import msu_pkg::*;

	msu_cmd_t    cmd;
	msu_stat_t   stat;
	msu_item_t   item_word;
	msu_result_t res_word;
	logic        res_valid;

	// Gather the item channel's payload into one word for the datapath.
	assign item_word.mode         = item.mode;
	assign item_word.atom_index   = item.atom_index;
	assign item_word.slot_index   = item.slot_index;
	assign item_word.link_index   = item.link_index;
	assign item_word.matrix_index = item.matrix_index;
	assign item_word.value        = item.value;
	assign item_word.prop_x       = item.prop_x;
	assign item_word.prop_y       = item.prop_y;
	assign item_word.prop_z       = item.prop_z;
	assign item_word.uniform      = item.uniform;

	// The sequencer owns the item handshake and steps the datapath through each word.
	msu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Stores, the multiply-accumulate pipeline, the divider and the output register.
	msu_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item_in   (item_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res_out   (res_word),
		.stat      (stat)
	);

	assign result.valid        = res_valid;
	assign result.spin_x       = res_word.spin_x;
	assign result.spin_y       = res_word.spin_y;
	assign result.spin_z       = res_word.spin_z;
	assign result.accepted     = res_word.accepted;
	assign result.energy_delta = res_word.energy_delta;
	assign result.flip_count   = res_word.flip_count;

endmodule
`default_nettype wire

>>> rtl/msu_checker.sv
`default_nettype none
`include "assert_macros.svh"
module msu_checker (
	input logic         clk,
	input logic         arst_n,
	msu_in_if.sink      item,
	msu_out_if.source   result
);
	logic item_acc, res_stall;

	assign item_acc  = item.valid && item.ready;
	assign res_stall = result.valid && !result.ready;

	// A result that is not accepted and has a nonzero energy change must show that the energy rose.
	`MSU_ASSERT_NOW(a_reject_rise, clk, arst_n, result.valid && !result.accepted && (result.energy_delta != 0), !result.energy_delta[31], "rejected trial with falling energy")
	// Words are processed one at a time.
	`MSU_ASSERT_NEXT(a_one_word, clk, arst_n, item_acc, !item.ready, "second word taken while busy")
	`MSU_ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, result.valid, "result withdrawn while stalled")
	`MSU_ASSERT_NEXT(a_res_stable, clk, arst_n, res_stall, $stable(result.flip_count) && $stable(result.spin_x) && $stable(result.energy_delta), "result changed while stalled")

endmodule

bind metropolis_spin_update_engine msu_checker u_msu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.result (result)
);
`default_nettype wire
